// ===== rtl/core/ber_value_content_encoder_defines.svh =====
// assertion macros for the ber value content encoder
// used by the top level only, no other dependencies
`ifndef BER_VALUE_CONTENT_ENCODER_DEFINES_SVH
`define BER_VALUE_CONTENT_ENCODER_DEFINES_SVH

// same-cycle implication
`define BVCE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// next-cycle implication
`define BVCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

// ===== rtl/core/bvce_pkg.sv =====
// types, constants and microcode rom of the ber value content encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bvce_pkg;

  localparam int PcWidth   = 4;
  localparam int AccWidth  = 38;
  localparam int WorkWidth = 35;
  localparam int CntWidth  = 3;
  localparam int MaxBytes  = 5;
  localparam int Mul40Hi   = 5;
  localparam int Mul40Lo   = 3;

  localparam logic [WorkWidth-1:0] CombinedLimit = '1;
  localparam logic [7:0]           ByteContinue  = 8'h80;
  localparam logic [6:0]           GroupMask     = 7'h7f;

  typedef logic [PcWidth-1:0]  pc_t;
  typedef logic [CntWidth-1:0] cnt_t;

  localparam pc_t StepWait   = 4'd0;
  localparam pc_t StepInt    = 4'd1;
  localparam pc_t StepMul    = 4'd2;
  localparam pc_t StepAdd    = 4'd3;
  localparam pc_t StepSat    = 4'd4;
  localparam pc_t StepSize   = 4'd5;
  localparam pc_t StepArc    = 4'd6;
  localparam pc_t StepEmit   = 4'd7;
  localparam pc_t StepOctet  = 4'd8;
  localparam pc_t StepSingle = 4'd9;
  localparam pc_t StepHold   = 4'd10;

  localparam logic [1:0] ActInt   = 2'd0;
  localparam logic [1:0] ActOid   = 2'd1;
  localparam logic [1:0] ActOctet = 2'd2;

  localparam logic [1:0] PosFirst  = 2'd0;
  localparam logic [1:0] PosSecond = 2'd1;
  localparam logic [1:0] PosLater  = 2'd2;

  typedef enum logic [3:0] {
    UOP_WAIT,
    UOP_LOAD_INT,
    UOP_MUL40,
    UOP_ADD_ARC,
    UOP_SAT,
    UOP_SIZE,
    UOP_LOAD_ARC,
    UOP_EMIT,
    UOP_LOAD_OCT,
    UOP_LOAD_SINGLE,
    UOP_HOLD
  } uop_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_DISPATCH,
    JMP_EMIT
  } jmp_t;

  typedef enum logic [1:0] {
    FMT_INT,
    FMT_RAW,
    FMT_B128
  } fmt_t;

  typedef struct packed {
    uop_t op;
    jmp_t jmp;
    pc_t  nxt;
  } ucode_t;

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    unique case (pc)
      StepWait:   w = '{op: UOP_WAIT,        jmp: JMP_DISPATCH, nxt: StepWait};
      StepInt:    w = '{op: UOP_LOAD_INT,    jmp: JMP_NEXT,     nxt: StepEmit};
      StepMul:    w = '{op: UOP_MUL40,       jmp: JMP_NEXT,     nxt: StepAdd};
      StepAdd:    w = '{op: UOP_ADD_ARC,     jmp: JMP_NEXT,     nxt: StepSat};
      StepSat:    w = '{op: UOP_SAT,         jmp: JMP_NEXT,     nxt: StepSize};
      StepSize:   w = '{op: UOP_SIZE,        jmp: JMP_NEXT,     nxt: StepEmit};
      StepArc:    w = '{op: UOP_LOAD_ARC,    jmp: JMP_NEXT,     nxt: StepSize};
      StepEmit:   w = '{op: UOP_EMIT,        jmp: JMP_EMIT,     nxt: StepWait};
      StepOctet:  w = '{op: UOP_LOAD_OCT,    jmp: JMP_NEXT,     nxt: StepEmit};
      StepSingle: w = '{op: UOP_LOAD_SINGLE, jmp: JMP_NEXT,     nxt: StepEmit};
      StepHold:   w = '{op: UOP_HOLD,        jmp: JMP_NEXT,     nxt: StepWait};
      default:    w = '{op: UOP_WAIT,        jmp: JMP_NEXT,     nxt: StepWait};
    endcase
    return w;
  endfunction

  // minimal two's complement length, a byte goes while it only repeats the sign
  function automatic cnt_t int_len(input logic [31:0] v);
    cnt_t n;
    n = 3'd4;
    if (v[31:23] == 9'h000 || v[31:23] == 9'h1ff) begin
      n = 3'd3;
      if (v[23:15] == 9'h000 || v[23:15] == 9'h1ff) begin
        n = 3'd2;
        if (v[15:7] == 9'h000 || v[15:7] == 9'h1ff) begin
          n = 3'd1;
        end
      end
    end
    return n;
  endfunction

  function automatic cnt_t b128_len(input logic [WorkWidth-1:0] v);
    cnt_t n;
    priority if (v[34:28] != 7'd0) begin
      n = 3'd5;
    end else if (v[27:21] != 7'd0) begin
      n = 3'd4;
    end else if (v[20:14] != 7'd0) begin
      n = 3'd3;
    end else if (v[13:7] != 7'd0) begin
      n = 3'd2;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bvce_in_if.sv =====
// input channel of the ber value content encoder: one item per handshake
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface bvce_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] int_value;
  logic [31:0]        arc;
  logic [7:0]         octet;
  logic               last_element;

  modport source (output valid, action, int_value, arc, octet, last_element, input ready);
  modport sink (input valid, action, int_value, arc, octet, last_element, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bvce_out_if.sv =====
// output channel of the ber value content encoder: one encoded byte per item
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface bvce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       value_end;

  modport source (output valid, out_byte, run_last, value_end, input ready);
  modport sink (input valid, out_byte, run_last, value_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ber_value_content_encoder.sv =====
// ber contents-octet encoder, microcoded sequencer over a small shift/add datapath
// depends on bvce_pkg, bvce_in_if, bvce_out_if and the defines header
//
// elem: input items (integer, oid arc, string byte, or no contents), valid/ready
// enc:  encoded bytes, one per item, with run_last and value_end flags
// one input item is worked on at a time; elem.ready is high only while the
// sequencer waits. steps per input item once it is accepted and registered:
//   integer or string byte or single first arc: load, then emit
//   second oid arc (40*first + second, saturated): multiply, add, saturate,
//     size, emit
//   later oid arc: load, size, emit
//   non-final first arc: hold, then wait; no-contents item: stays in wait
// the emit step sends one byte per cycle while the receiver is ready
// a stalled receiver holds the emit step and its byte; nothing is lost
// synchronous reset returns to the wait step and clears the oid position and
// the held first arc
`timescale 1ns / 1ps
`default_nettype none
`include "ber_value_content_encoder_defines.svh"

module ber_value_content_encoder
  import bvce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bvce_in_if.sink     elem,
  bvce_out_if.source  enc
);

  pc_t                   pc;
  pc_t                   pc_next;
  pc_t                   dispatch;
  ucode_t                ctrl;
  cnt_t                  cnt;
  cnt_t                  byte_idx;
  fmt_t                  fmt;
  logic [AccWidth-1:0]   acc;
  logic [31:0]           ival_r;
  logic [31:0]           arc_r;
  logic [7:0]            oct_r;
  logic                  last_r;
  logic [1:0]            arc_position;
  logic [31:0]           first_arc_hold;
  logic                  accept_in;
  logic                  accept_out;
  logic [7:0]            int_byte;
  logic [6:0]            grp;

  assign ctrl       = ucode_rom(pc);
  assign accept_in  = elem.valid && elem.ready;
  assign accept_out = enc.valid && enc.ready;

  // entry step for an accepted item
  always_comb begin
    priority if (elem.action == ActInt) begin
      dispatch = StepInt;
    end else if (elem.action == ActOctet) begin
      dispatch = StepOctet;
    end else if (elem.action != ActOid) begin
      dispatch = StepWait;
    end else if (arc_position == PosFirst) begin
      dispatch = elem.last_element ? StepSingle : StepHold;
    end else if (arc_position == PosSecond) begin
      dispatch = StepMul;
    end else begin
      dispatch = StepArc;
    end
  end

  always_comb begin
    pc_next = pc;
    unique case (ctrl.jmp)
      JMP_NEXT: begin
        pc_next = ctrl.nxt;
      end
      JMP_DISPATCH: begin
        if (accept_in) pc_next = dispatch;
      end
      JMP_EMIT: begin
        if (accept_out && cnt == 3'd1) pc_next = ctrl.nxt;
      end
      default: begin
        pc_next = StepWait;
      end
    endcase
  end

  // output byte selection
  always_comb begin
    byte_idx = cnt - 3'd1;
    unique case (byte_idx)
      3'd0:    int_byte = acc[7:0];
      3'd1:    int_byte = acc[15:8];
      3'd2:    int_byte = acc[23:16];
      3'd3:    int_byte = acc[31:24];
      default: int_byte = 8'h00;
    endcase
    unique case (byte_idx)
      3'd0:    grp = acc[6:0] & GroupMask;
      3'd1:    grp = acc[13:7];
      3'd2:    grp = acc[20:14];
      3'd3:    grp = acc[27:21];
      3'd4:    grp = acc[34:28];
      default: grp = 7'd0;
    endcase
  end

  always_comb begin
    elem.ready    = (ctrl.op == UOP_WAIT);
    enc.valid     = (ctrl.op == UOP_EMIT);
    enc.run_last  = (cnt == 3'd1);
    enc.value_end = (cnt == 3'd1) && (fmt == FMT_INT || last_r);
    if (fmt == FMT_B128) begin
      enc.out_byte = (byte_idx != 3'd0) ? (ByteContinue | {1'b0, grp}) : {1'b0, grp};
    end else begin
      enc.out_byte = int_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc             <= StepWait;
      cnt            <= '0;
      arc_position   <= PosFirst;
      first_arc_hold <= '0;
    end else begin
      pc <= pc_next;
      if (accept_in) begin
        ival_r <= elem.int_value;
        arc_r  <= elem.arc;
        oct_r  <= elem.octet;
        last_r <= elem.last_element;
        if (elem.action != ActOid) begin
          arc_position   <= PosFirst;
          first_arc_hold <= '0;
        end
      end
      unique case (ctrl.op)
        UOP_LOAD_INT: begin
          acc <= AccWidth'(ival_r);
          fmt <= FMT_INT;
          cnt <= int_len(ival_r);
        end
        UOP_MUL40: begin
          acc <= AccWidth'({first_arc_hold, Mul40Hi'(0)})
               + AccWidth'({first_arc_hold, Mul40Lo'(0)});
        end
        UOP_ADD_ARC: begin
          acc <= acc + AccWidth'(arc_r);
          if (last_r) begin
            arc_position   <= PosFirst;
            first_arc_hold <= '0;
          end else begin
            arc_position <= PosLater;
          end
        end
        UOP_SAT: begin
          if (acc[AccWidth-1:WorkWidth] != '0) acc <= AccWidth'(CombinedLimit);
        end
        UOP_SIZE: begin
          fmt <= FMT_B128;
          cnt <= b128_len(acc[WorkWidth-1:0]);
        end
        UOP_LOAD_ARC: begin
          acc <= AccWidth'(arc_r);
          if (last_r) begin
            arc_position   <= PosFirst;
            first_arc_hold <= '0;
          end else begin
            arc_position <= PosLater;
          end
        end
        UOP_EMIT: begin
          if (accept_out) cnt <= cnt - 3'd1;
        end
        UOP_LOAD_OCT: begin
          acc <= AccWidth'(oct_r);
          fmt <= FMT_RAW;
          cnt <= 3'd1;
        end
        UOP_LOAD_SINGLE: begin
          acc            <= AccWidth'(arc_r[7:0]);
          fmt            <= FMT_RAW;
          cnt            <= 3'd1;
          first_arc_hold <= '0;
        end
        UOP_HOLD: begin
          first_arc_hold <= arc_r;
          arc_position   <= PosSecond;
        end
        UOP_WAIT: begin
        end
        default: begin
        end
      endcase
    end
  end

  `BVCE_ASSERT_IMPL(a_cnt_range, clk, rst, enc.valid, cnt != 3'd0 && cnt <= CntWidth'(MaxBytes))
  `BVCE_ASSERT_IMPL(a_no_overlap, clk, rst, elem.valid && elem.ready, !enc.valid)
  `BVCE_ASSERT_NEXT(a_hold_second, clk, rst, ctrl.op == UOP_HOLD, arc_position == PosSecond)
  `BVCE_ASSERT_IMPL(a_end_is_last, clk, rst, enc.valid && enc.value_end, enc.run_last)

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench for ber_value_content_encoder: bytes are predicted from each accepted item
// depends on bvce_pkg, bvce_in_if, bvce_out_if and the encoder rtl
`timescale 1ns / 1ps

module tb
  import bvce_pkg::*;
();

  localparam logic [1:0]  ActNone    = 2'd3;
  localparam logic [34:0] SatLimit   = 35'h7_ffff_ffff;
  localparam int          RandItems  = 350;
  localparam time         RunLimit   = 5ms;

  typedef struct {
    logic [1:0]         action;
    logic signed [31:0] int_value;
    logic [31:0]        arc;
    logic [7:0]         octet;
    logic               last_element;
  } elem_item_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       run_last;
    logic       value_end;
  } enc_byte_t;

  logic clk;
  logic rst;

  bvce_in_if  elem_bus ();
  bvce_out_if enc_bus ();

  ber_value_content_encoder DUT (
    .clk  (clk),
    .rst  (rst),
    .elem (elem_bus),
    .enc  (enc_bus)
  );

  elem_item_t pending_items[$];
  enc_byte_t  expected_bytes[$];

  logic [31:0] held_arc;
  logic [1:0]  arc_pos;

  int errors;
  int accepted_cnt;
  int total_items;
  int counted;
  bit in_took;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void push_byte(input logic [7:0] b, input logic rl, input logic ve);
    enc_byte_t e;
    e.out_byte  = b;
    e.run_last  = rl;
    e.value_end = ve;
    expected_bytes.push_back(e);
  endfunction

  function automatic void push_base128(input logic [34:0] v, input logic ve);
    int n;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    for (int k = n - 1; k >= 0; k--) begin
      push_byte({k != 0, v[7*k +: 7]}, k == 0, (k == 0) && ve);
    end
  endfunction

  function automatic void push_integer(input logic [31:0] bits);
    int n;
    n = 4;
    // drop a leading byte while it only repeats the sign of the next one
    while (n > 1 && (bits[n*8-1 -: 9] == 9'h000 || bits[n*8-1 -: 9] == 9'h1ff)) n--;
    for (int k = n - 1; k >= 0; k--) begin
      push_byte(bits[8*k +: 8], k == 0, k == 0);
    end
  endfunction

  function automatic void encode_item(input elem_item_t it);
    logic [63:0] combined;
    if (it.action != ActOid) begin
      arc_pos  = PosFirst;
      held_arc = '0;
      if (it.action == ActInt) begin
        push_integer(it.int_value);
      end else if (it.action == ActOctet) begin
        push_byte(it.octet, 1'b1, it.last_element);
      end
      return;
    end
    if (arc_pos == PosFirst) begin
      if (it.last_element) begin
        push_byte(it.arc[7:0], 1'b1, 1'b1);
        held_arc = '0;
      end else begin
        held_arc = it.arc;
        arc_pos  = PosSecond;
      end
      return;
    end
    if (arc_pos == PosSecond) begin
      combined = {32'd0, held_arc} * 64'd40 + {32'd0, it.arc};
      if (combined > {29'd0, SatLimit}) combined = {29'd0, SatLimit};
      push_base128(combined[34:0], it.last_element);
    end else begin
      push_base128({3'd0, it.arc}, it.last_element);
    end
    if (it.last_element) begin
      arc_pos  = PosFirst;
      held_arc = '0;
    end else begin
      arc_pos = PosLater;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void add_item(input logic [1:0] act, input logic [31:0] ival,
                                   input logic [31:0] arcv, input logic [7:0] oct,
                                   input logic lastel);
    elem_item_t it;
    it.action       = act;
    it.int_value    = (act == ActInt)   ? ival : $urandom;
    it.arc          = (act == ActOid)   ? arcv : $urandom;
    it.octet        = (act == ActOctet) ? oct  : $urandom;
    it.last_element = lastel;
    pending_items.push_back(it);
    if (act != ActNone) counted++;
  endfunction

  function automatic logic [31:0] rand_sized();
    int w;
    w = $urandom_range(32, 1);
    if (w == 32) return $urandom;
    return $urandom & ((32'd1 << w) - 1);
  endfunction

  function automatic logic [31:0] rand_arc();
    if ($urandom_range(1, 0)) return $urandom_range(200, 0);
    return rand_sized();
  endfunction

  task automatic build_directed();
    logic [31:0] ints[] = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_007f, 32'h0000_0080,
                            32'hffff_ff80, 32'hffff_ff7f, 32'h0000_7fff, 32'hffff_8000,
                            32'h007f_ffff, 32'hff80_0000, 32'h7fff_ffff, 32'h8000_0000};
    foreach (ints[i]) add_item(ActInt, ints[i], 0, 0, $urandom_range(1, 0));
    add_item(ActOctet, 0, 0, 8'h00, 1'b0);
    add_item(ActOctet, 0, 0, 8'hff, 1'b1);
    add_item(ActNone, 0, 0, 0, 1'b1);
    // single-arc identifier
    add_item(ActOid, 0, 32'hffff_ffff, 0, 1'b1);
    // 1.2.840.113549
    add_item(ActOid, 0, 32'd1, 0, 1'b0);
    add_item(ActOid, 0, 32'd2, 0, 1'b0);
    add_item(ActOid, 0, 32'd840, 0, 1'b0);
    add_item(ActOid, 0, 32'd113549, 0, 1'b1);
    // combined first arcs saturate, then a full-width later arc
    add_item(ActOid, 0, 32'hffff_ffff, 0, 1'b0);
    add_item(ActOid, 0, 32'hffff_ffff, 0, 1'b0);
    add_item(ActOid, 0, 32'hffff_ffff, 0, 1'b1);
    // identifiers cut short by other kinds
    add_item(ActOid, 0, 32'd2, 0, 1'b0);
    add_item(ActNone, 0, 0, 0, 1'b0);
    add_item(ActOid, 0, 32'd0, 0, 1'b0);
    add_item(ActOid, 0, 32'd39, 0, 1'b0);
    add_item(ActOctet, 0, 0, 8'h5a, 1'b1);
  endtask

  task automatic build_random();
    int r;
    int len;
    logic [31:0] v;
    while (counted < RandItems) begin
      r = $urandom_range(99, 0);
      if (r < 35) begin
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++) begin
          v = (i == 0 && $urandom_range(3, 0) != 0) ? $urandom_range(2, 0) : rand_arc();
          add_item(ActOid, 0, v, 0, i == len - 1);
        end
      end else if (r < 55) begin
        v = rand_sized();
        if ($urandom_range(1, 0)) v = ~v;
        add_item(ActInt, v, 0, 0, $urandom_range(1, 0));
      end else if (r < 75) begin
        len = $urandom_range(5, 1);
        for (int i = 0; i < len; i++) add_item(ActOctet, 0, 0, $urandom, i == len - 1);
      end else if (r < 80) begin
        add_item(ActNone, 0, 0, 0, $urandom_range(1, 0));
      end else if (r < 90) begin
        len = $urandom_range(3, 1);
        for (int i = 0; i < len; i++) add_item(ActOid, 0, rand_arc(), 0, 1'b0);
      end else begin
        add_item($urandom_range(3, 0), $urandom, $urandom, $urandom, $urandom_range(1, 0));
      end
    end
  endtask

  // ---------------------------------------------------------------- idling

  function automatic int sender_idle_pct();
    if (accepted_cnt * 3 < total_items) return 22;
    if (accepted_cnt * 3 < total_items * 2) return 46;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (accepted_cnt * 3 < total_items) return 46;
    if (accepted_cnt * 3 < total_items * 2) return 22;
    return 0;
  endfunction

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin
    elem_item_t it;
    enc_bus.ready <= ($urandom_range(99, 0) >= receiver_stall_pct());
    if (!rst && (!elem_bus.valid || in_took)) begin
      if (pending_items.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct()) begin
        it = pending_items.pop_front();
        elem_bus.valid        <= 1'b1;
        elem_bus.action       <= it.action;
        elem_bus.int_value    <= it.int_value;
        elem_bus.arc          <= it.arc;
        elem_bus.octet        <= it.octet;
        elem_bus.last_element <= it.last_element;
      end else begin
        elem_bus.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    elem_item_t it;
    enc_byte_t  want;
    in_took = 1'b0;
    if (!rst) begin
      if (elem_bus.valid && elem_bus.ready) begin
        it.action       = elem_bus.action;
        it.int_value    = elem_bus.int_value;
        it.arc          = elem_bus.arc;
        it.octet        = elem_bus.octet;
        it.last_element = elem_bus.last_element;
        encode_item(it);
        accepted_cnt++;
        in_took = 1'b1;
      end
      if (enc_bus.valid && enc_bus.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte %h", enc_bus.out_byte);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (enc_bus.out_byte !== want.out_byte) begin
            $error("out_byte expected %h got %h", want.out_byte, enc_bus.out_byte);
            errors++;
          end
          if (enc_bus.run_last !== want.run_last) begin
            $error("run_last expected %b got %b", want.run_last, enc_bus.run_last);
            errors++;
          end
          if (enc_bus.value_end !== want.value_end) begin
            $error("value_end expected %b got %b", want.value_end, enc_bus.value_end);
            errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst                   = 1'b1;
    elem_bus.valid        = 1'b0;
    elem_bus.action       = ActNone;
    elem_bus.int_value    = '0;
    elem_bus.arc          = '0;
    elem_bus.octet        = '0;
    elem_bus.last_element = 1'b0;
    enc_bus.ready         = 1'b0;
    held_arc              = '0;
    arc_pos               = PosFirst;
    errors                = 0;
    accepted_cnt          = 0;
    counted               = 0;
    in_took               = 1'b0;
    build_directed();
    build_random();
    total_items = pending_items.size();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (pending_items.size() != 0 || elem_bus.valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #RunLimit;
    $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bvce_pkg.sv
rtl/core/bvce_in_if.sv
rtl/core/bvce_out_if.sv
rtl/core/ber_value_content_encoder.sv
verif/tb.sv
